/* hw/rtl/windowed_rms_voltage_monitor_top_defines.svh */
// ============================================================================
// windowed_rms_voltage_monitor_top_defines.svh
// Assertion macros for the monitor RTL.
// ============================================================================
`ifndef WINDOWED_RMS_VOLTAGE_MONITOR_TOP_DEFINES_SVH
`define WINDOWED_RMS_VOLTAGE_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/wrvm_pkg.sv */
// ============================================================================
// wrvm_pkg
// Types, widths and codes shared by the RMS voltage monitor modules.
// ============================================================================
package wrvm_pkg;

    localparam int ADC_BITS = 12;
    localparam int CNT_BITS = 16;
    localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
    localparam logic [CNT_BITS-1:0] CNT_FULL = '1;

    localparam int SUM_W   = 28;
    localparam int SQS_W   = 40;
    localparam int SQS_LO  = 20;
    localparam int DIFF_W  = 56;
    localparam int DEN_W   = 32;
    localparam int Q_W     = 40;
    localparam int RMS_W   = 20;
    localparam int SREM_W  = 22;
    localparam int V_W     = 24;
    localparam int CFG_W   = 24;
    localparam int MUL_W   = 29;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SC_W    = 46;
    localparam int OUT_W   = 112;
    localparam int FLAG_W  = 2;

    localparam int DIV_STEPS  = 40;
    localparam int SQRT_STEPS = 20;
    localparam int STEP_W     = 6;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN    = 3'd0;
    localparam logic [2:0] CFG_OFFSET  = 3'd1;
    localparam logic [2:0] CFG_HASCAL  = 3'd2;
    localparam logic [2:0] CFG_WINMS   = 3'd3;
    localparam logic [2:0] CFG_SATFRAC = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_NLO, S_NHI, S_DEN, S_DIFF, S_DIV, S_SQRT,
        S_VRMS, S_VMIN, S_VMAX, S_SAT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_SAMPLE, OP_TICK, OP_SQ, OP_NLO, OP_NHI, OP_DEN, OP_DIFF,
        OP_DIV, OP_SQRT, OP_VRMS, OP_VMIN, OP_VMAX, OP_SAT, OP_DONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic close;   // next tick ends the window
        logic empty;   // no samples in the window
    } t_stat;

    // Clamp to the signed 24-bit range
    function automatic logic [V_W-1:0] sat_v(input logic signed [SC_W-1:0] v);
        logic [V_W-1:0] res;
        if (v > SC_W'(signed'(24'sh7FFFFF))) begin
            res = 24'h7FFFFF;
        end else if (v < -SC_W'(signed'(25'sh0800000))) begin
            res = 24'h800000;
        end else begin
            res = v[V_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/wrvm_ctrl.sv */
// ============================================================================
// wrvm_ctrl
// Sequencer: accepts items in idle, steps the datapath through a window close.
// ============================================================================
module wrvm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    input  logic            i_func,
    output logic            o_s_axis_tready,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    input  wrvm_pkg::t_stat i_stat,
    output wrvm_pkg::t_cmd  o_cmd
);
    import wrvm_pkg::*;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_mvalid, n_mvalid;
    logic w_out_free;

    assign w_out_free = !r_mvalid || i_m_axis_tready;

    // State, iteration counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_mvalid <= n_mvalid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid && i_func && i_stat.close && !i_stat.empty) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:   n_state = S_NLO;
            S_NLO:  n_state = S_NHI;
            S_NHI:  n_state = S_DEN;
            S_DEN:  n_state = S_DIFF;
            S_DIFF: n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_SQRT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_VRMS;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_VRMS: n_state = S_VMIN;
            S_VMIN: n_state = S_VMAX;
            S_VMAX: n_state = S_SAT;
            S_SAT:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.op        = OP_NONE;
        o_s_axis_tready = 1'b0;
        n_mvalid        = r_mvalid && !i_m_axis_tready;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.op = i_func ? OP_TICK : OP_SAMPLE;
                end
            end
            S_SQ:   o_cmd.op = OP_SQ;
            S_NLO:  o_cmd.op = OP_NLO;
            S_NHI:  o_cmd.op = OP_NHI;
            S_DEN:  o_cmd.op = OP_DEN;
            S_DIFF: o_cmd.op = OP_DIFF;
            S_DIV:  o_cmd.op = OP_DIV;
            S_SQRT: o_cmd.op = OP_SQRT;
            S_VRMS: o_cmd.op = OP_VRMS;
            S_VMIN: o_cmd.op = OP_VMIN;
            S_VMAX: o_cmd.op = OP_VMAX;
            S_SAT:  o_cmd.op = OP_SAT;
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.op = OP_DONE;
                    n_mvalid = 1'b1;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_m_axis_tvalid = r_mvalid;

endmodule

/* hw/rtl/wrvm_dp.sv */
// ============================================================================
// wrvm_dp
// Datapath: config registers, window accumulators, shared multiplier,
// bit-serial divider and square root, output register.
// ============================================================================
module wrvm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [wrvm_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [wrvm_pkg::ADC_BITS-1:0] i_raw,
    input  wrvm_pkg::t_cmd                i_cmd,
    output wrvm_pkg::t_stat               o_stat,
    output logic [wrvm_pkg::OUT_W-1:0]    o_data,
    output logic [wrvm_pkg::FLAG_W-1:0]   o_flags
);
    import wrvm_pkg::*;

    // Configuration
    logic [V_W-1:0]      r_gain, r_offset;
    logic                r_hascal;
    logic [CNT_BITS-1:0] r_winms, r_satfrac;

    // Window state
    logic [CNT_BITS-1:0] r_ms, r_cnt, r_rail;
    logic [SUM_W-1:0]    r_sum;
    logic [SQS_W-1:0]    r_sqs;
    logic [ADC_BITS-1:0] r_min, r_max;

    // Close computation
    logic signed [PROD_W-1:0] r_prod;
    logic [DIFF_W-1:0]   r_sq, r_acc;
    logic [DEN_W-1:0]    r_den, r_rem;
    logic [Q_W-1:0]      r_q;
    logic [SREM_W-1:0]   r_srem;
    logic [RMS_W-1:0]    r_root;
    logic [V_W-1:0]      r_vrms, r_vmin, r_vmax;
    logic [OUT_W-1:0]    r_out;
    logic [FLAG_W-1:0]   r_flags;

    logic [CNT_BITS-1:0] w_ms_inc;
    logic signed [MUL_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_mul;
    logic                w_mul_en;
    logic [DIFF_W-1:0]   w_diff;
    logic [DEN_W:0]      w_dt, w_dsub;
    logic                w_dge;
    logic [SREM_W+1:0]   w_st, w_strial, w_ssub;
    logic                w_sge;
    logic signed [SC_W-2:0] w_p, w_sh16, w_sh8;
    logic signed [SC_W-1:0] w_off;
    logic [2*ADC_BITS-1:0] w_rsq;
    logic                w_sat;

    assign w_ms_inc     = (r_ms == CNT_FULL) ? r_ms : r_ms + 1'b1;
    assign o_stat.close = (w_ms_inc >= r_winms);
    assign o_stat.empty = (r_cnt == '0);

    // Multiplier operand select
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b1;
        case (i_cmd.op)
            OP_SQ: begin
                w_ma = MUL_W'(r_sum);
                w_mb = MUL_W'(r_sum);
            end
            OP_NLO: begin
                w_ma = MUL_W'(r_cnt);
                w_mb = MUL_W'(r_sqs[SQS_LO-1:0]);
            end
            OP_NHI: begin
                w_ma = MUL_W'(r_cnt);
                w_mb = MUL_W'(r_sqs[SQS_W-1:SQS_LO]);
            end
            OP_DEN: begin
                w_ma = MUL_W'(r_cnt);
                w_mb = MUL_W'(r_cnt);
            end
            OP_VRMS: begin
                w_ma = MUL_W'(r_root);
                w_mb = MUL_W'(signed'(r_gain));
            end
            OP_VMIN: begin
                w_ma = MUL_W'(r_min);
                w_mb = MUL_W'(signed'(r_gain));
            end
            OP_VMAX: begin
                w_ma = MUL_W'(r_max);
                w_mb = MUL_W'(signed'(r_gain));
            end
            OP_SAT: begin
                w_ma = MUL_W'(r_satfrac);
                w_mb = MUL_W'(r_cnt);
            end
            default: w_mul_en = 1'b0;
        endcase
    end
    assign w_mul = w_ma * w_mb;

    // Variance numerator, clamped at zero
    assign w_diff = (r_acc < r_sq) ? '0 : r_acc - r_sq;

    // Restoring divide step
    assign w_dt   = {r_rem, r_q[Q_W-1]};
    assign w_dsub = w_dt - {1'b0, r_den};
    assign w_dge  = (w_dt >= {1'b0, r_den});

    // Square-root digit step
    assign w_st     = {r_srem, r_q[Q_W-1:Q_W-2]};
    assign w_strial = (SREM_W+2)'({r_root, 2'b01});
    assign w_ssub   = w_st - w_strial;
    assign w_sge    = (w_st >= w_strial);

    // Floor scaling of the registered product, plus offset
    assign w_p    = r_prod[SC_W-2:0];
    assign w_sh16 = w_p >>> 16;
    assign w_sh8  = w_p >>> 8;
    assign w_off  = SC_W'(signed'(r_offset));

    assign w_rsq = i_raw * i_raw;
    assign w_sat = ({r_rail, 16'b0} > r_prod[31:0]);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= V_W'(65536);
            r_offset  <= '0;
            r_hascal  <= 1'b0;
            r_winms   <= CNT_BITS'(1000);
            r_satfrac <= CNT_BITS'(655);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:    r_gain    <= i_cfg_data;
                CFG_OFFSET:  r_offset  <= i_cfg_data;
                CFG_HASCAL:  r_hascal  <= i_cfg_data[0];
                CFG_WINMS:   r_winms   <= i_cfg_data[CNT_BITS-1:0];
                CFG_SATFRAC: r_satfrac <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Window accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == OP_DONE) begin
            r_ms   <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_sqs  <= '0;
            r_rail <= '0;
            r_min  <= ADC_FULL;
            r_max  <= '0;
        end else if (i_cmd.op == OP_SAMPLE) begin
            if (r_cnt < CNT_FULL) begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= r_sum + SUM_W'(i_raw);
                r_sqs <= r_sqs + SQS_W'(w_rsq);
                if (i_raw == '0 || i_raw == ADC_FULL) begin
                    r_rail <= r_rail + 1'b1;
                end
                if (i_raw < r_min) begin
                    r_min <= i_raw;
                end
                if (i_raw > r_max) begin
                    r_max <= i_raw;
                end
            end
        end else if (i_cmd.op == OP_TICK) begin
            r_ms <= (o_stat.close && o_stat.empty) ? '0 : w_ms_inc;
        end
    end

    // Close computation
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul;
        end
        case (i_cmd.op)
            OP_NLO: r_sq  <= r_prod[DIFF_W-1:0];
            OP_NHI: r_acc <= r_prod[DIFF_W-1:0];
            OP_DEN: r_acc <= r_acc + {r_prod[DIFF_W-SQS_LO-1:0], SQS_LO'(0)};
            OP_DIFF: begin
                r_den  <= r_prod[DEN_W-1:0];
                r_rem  <= w_diff[DIFF_W-1:DIFF_W-DEN_W];
                r_q    <= {w_diff[DIFF_W-DEN_W-1:0], 16'b0};
                r_srem <= '0;
                r_root <= '0;
            end
            OP_DIV: begin
                r_rem <= w_dge ? w_dsub[DEN_W-1:0] : w_dt[DEN_W-1:0];
                r_q   <= {r_q[Q_W-2:0], w_dge};
            end
            OP_SQRT: begin
                r_srem <= w_sge ? w_ssub[SREM_W-1:0] : w_st[SREM_W-1:0];
                r_root <= {r_root[RMS_W-2:0], w_sge};
                r_q    <= {r_q[Q_W-3:0], 2'b00};
            end
            OP_VMIN: r_vrms <= sat_v(SC_W'(w_sh16) + w_off);
            OP_VMAX: r_vmin <= sat_v(SC_W'(w_sh8) + w_off);
            OP_SAT:  r_vmax <= sat_v(SC_W'(w_sh8) + w_off);
            OP_DONE: begin
                r_out   <= {4'b0, r_cnt, r_vmax, r_vmin, r_vrms, r_root};
                r_flags <= {w_sat, !r_hascal};
            end
            default: ;
        endcase
    end

    assign o_data  = r_out;
    assign o_flags = r_flags;

endmodule

/* hw/rtl/windowed_rms_voltage_monitor_top.sv */
// ============================================================================
// windowed_rms_voltage_monitor_top
// Windowed AC RMS / min / max voltage meter with gain and offset scaling.
// ============================================================================
// Input stream: tuser[0] is func (0 = ADC sample, 1 = millisecond tick),
// tdata[11:0] is the raw sample. Samples and ticks that do not close a
// window are taken in idle and leave the sequencer idle. A tick that closes
// a non-empty window starts the report sequence: four multiplier steps and an
// operand load, a bit-serial divide, a square root, four scaling steps and a
// hand-off step, during which tready is low. The report lands in an output
// register at the hand-off; the input side reopens while it waits to be taken.
// If a second report is ready while the first is still stalled, the sequencer
// holds it, with tready low, until the output frees.
// Output stream: tdata holds raw_rms, vrms, vmin, vmax and the window's sample
// total, tuser holds the flags. Configuration is written through i_cfg_*;
// the user must write it only while idle, as the block does not enforce this.
// Reset is synchronous and restores the default registers and an empty window.
// ============================================================================
module windowed_rms_voltage_monitor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input items
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [15:0]  i_s_axis_tdata,   // [11:0] raw, [15:12] zero
    input  logic [0:0]   i_s_axis_tuser,   // [0] func
    // Result items
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata,   // [19:0] raw_rms, [43:20] vrms,
                                           // [67:44] vmin, [91:68] vmax,
                                           // [107:92] num_samples, [111:108] 0
    output logic [1:0]   o_m_axis_tuser,   // [1:0] flags
    // Configuration
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data
);
    import wrvm_pkg::*;
    `include "windowed_rms_voltage_monitor_top_defines.svh"

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_acc;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Sequencer
    wrvm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_func          (i_s_axis_tuser[0]),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    // Datapath
    wrvm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_raw      (i_s_axis_tdata[ADC_BITS-1:0]),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_data     (o_m_axis_tdata),
        .o_flags    (o_m_axis_tuser)
    );

    // A closing tick on a non-empty window makes the block busy
    `AST_NEXT(a_close_busy, i_clk, i_rst_n,
              w_in_acc && i_s_axis_tuser[0] && w_stat.close && !w_stat.empty,
              !o_s_axis_tready)
    // A report always carries at least one sample
    `AST_IMPL(a_count_nonzero, i_clk, i_rst_n, o_m_axis_tvalid,
              o_m_axis_tdata[107:92] != 16'd0)
    // A new report appears only after a sequence, never straight from idle
    `AST_IMPL(a_rise_after_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid),
              !$past(o_s_axis_tready))

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for windowed_rms_voltage_monitor_top
// Sends ADC samples and millisecond ticks through the input stream and checks
// each window report against a bit-exact software meter kept in step with the
// accepted items. Both stream sides idle at random. Configuration changes only
// between phases, once every report is in.
// ----------------------------------------------------------------------------
module tb;
    import wrvm_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int SETTLE      = 120;

    typedef struct packed {
        logic [19:0] rms;
        logic [23:0] vrms;
        logic [23:0] vmin;
        logic [23:0] vmax;
        logic [15:0] cnt;
        logic [1:0]  flags;
    } report_t;

    typedef struct packed {
        logic        tick;
        logic [11:0] raw;
    } meter_item_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [15:0]  i_s_axis_tdata = '0;
    logic [0:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [111:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [23:0]  i_cfg_data = '0;

    windowed_rms_voltage_monitor_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Software meter: configuration and window state
    logic [23:0] m_gain, m_offset;
    logic        m_hascal;
    logic [15:0] m_winms, m_satfrac;
    logic [15:0] m_ms, m_cnt, m_rails;
    logic [27:0] m_sum;
    logic [39:0] m_sqs;
    logic [11:0] m_min, m_max;

    meter_item_t pending_items[$];
    report_t     expected_reports[$];
    int          errors = 0;
    int          reports_seen = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          tx_quiet = 0, rx_quiet = 0;
    int          rx_hold = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH report %0d %s: got %0h want %0h", reports_seen, what, got, want);
    endtask

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // AC RMS in Q12.8: sqrt(floor((n*sumsq - sum^2) * 2^16 / n^2))
    function automatic logic [19:0] ac_rms_q8();
        logic [127:0] a, b, q;
        logic [63:0]  r;
        a = 128'(m_cnt) * 128'(m_sqs);
        b = 128'(m_sum) * 128'(m_sum);
        if (a < b) return '0;
        q = ((a - b) << 16) / (128'(m_cnt) * 128'(m_cnt));
        r = isqrt(q[63:0]);
        return (r > 64'hFFFFF) ? 20'hFFFFF : r[19:0];
    endfunction

    // floor(prod / 2^sh) + offset, clamped to signed 24 bits
    function automatic logic [23:0] to_volts(input longint prod, input int sh);
        longint v;
        v = (prod >>> sh) + longint'($signed(m_offset));
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[23:0];
    endfunction

    function automatic void clear_window();
        m_ms = 0; m_cnt = 0; m_sum = 0; m_sqs = 0; m_rails = 0;
        m_min = ADC_FULL; m_max = 0;
    endfunction

    // Advance the meter by one accepted item; queue a report on a window close
    function automatic void meter_step(input meter_item_t it);
        report_t rp;
        longint  g;
        if (!it.tick) begin
            if (m_cnt != CNT_FULL) begin
                m_cnt++;
                m_sum += 28'(it.raw);
                m_sqs += 40'(it.raw) * 40'(it.raw);
                if (it.raw == 0 || it.raw == ADC_FULL) m_rails++;
                if (it.raw < m_min) m_min = it.raw;
                if (it.raw > m_max) m_max = it.raw;
            end
            return;
        end
        if (m_ms != 16'hFFFF) m_ms++;
        if (m_ms < m_winms) return;
        if (m_cnt == 0) begin
            m_ms = 0;
            return;
        end
        g = longint'($signed(m_gain));
        rp.rms   = ac_rms_q8();
        rp.vrms  = to_volts(longint'(rp.rms) * g, 16);
        rp.vmin  = to_volts(longint'(m_min) * g, 8);
        rp.vmax  = to_volts(longint'(m_max) * g, 8);
        rp.cnt   = m_cnt;
        rp.flags[0] = !m_hascal;
        rp.flags[1] = (64'(m_rails) << 16) > 64'(m_satfrac) * 64'(m_cnt);
        expected_reports.push_back(rp);
        clear_window();
    endfunction

    function automatic int gap_len(input bit quiet);
        if (quiet || $urandom_range(5) != 0) return 0;
        return ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
    endfunction

    // Input driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        meter_item_t it;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                meter_step({i_s_axis_tuser[0], i_s_axis_tdata[11:0]});
                items_sent++;
                tx_gap = gap_len(tx_quiet);
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // hold the offered item
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= it.tick;
                i_s_axis_tdata  <= {4'd0, it.raw};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down in cycles
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end
    end

    // Result monitor and receiver stalls
    int rx_gap = 0;
    always @(posedge i_clk) begin
        report_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata[19:0], o_m_axis_tdata[43:20], o_m_axis_tdata[67:44],
                       o_m_axis_tdata[91:68], o_m_axis_tdata[107:92], o_m_axis_tuser};
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected report", 64'(got.cnt), 64'd0);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.rms != want.rms)
                        report_mismatch("raw_rms", 64'(got.rms), 64'(want.rms));
                    if (got.vrms != want.vrms)
                        report_mismatch("vrms", 64'(got.vrms), 64'(want.vrms));
                    if (got.vmin != want.vmin)
                        report_mismatch("vmin", 64'(got.vmin), 64'(want.vmin));
                    if (got.vmax != want.vmax)
                        report_mismatch("vmax", 64'(got.vmax), 64'(want.vmax));
                    if (got.cnt != want.cnt)
                        report_mismatch("count", 64'(got.cnt), 64'(want.cnt));
                    if (got.flags != want.flags)
                        report_mismatch("flags", 64'(got.flags), 64'(want.flags));
                end
            end
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                rx_gap = gap_len(rx_quiet);
                i_m_axis_tready <= (rx_gap == 0);
            end
        end
    end

    // Wait until everything sent has been taken and every report checked
    task automatic drain();
        while (pending_items.size() != 0 || i_s_axis_tvalid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_GAIN:    m_gain    = val;
            CFG_OFFSET:  m_offset  = val;
            CFG_HASCAL:  m_hascal  = val[0];
            CFG_WINMS:   m_winms   = val[15:0];
            CFG_SATFRAC: m_satfrac = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_sample(input logic [11:0] raw);
        pending_items.push_back('{tick: 1'b0, raw: raw});
    endtask

    task automatic push_ticks(input int n);
        repeat (n) pending_items.push_back('{tick: 1'b1, raw: 12'($urandom)});
    endtask

    function automatic logic [11:0] rand_raw();
        case ($urandom_range(5))
            0: return 12'd0;
            1: return ADC_FULL;
            2: return 12'($urandom_range(2100, 2000));
            default: return 12'($urandom);
        endcase
    endfunction

    // One window of random content, sometimes empty
    task automatic push_window(input int max_samples);
        int ns;
        ns = ($urandom_range(7) == 0) ? 0 : $urandom_range(max_samples, 1);
        repeat (ns) push_sample(rand_raw());
        push_ticks(m_winms);
    endtask

    initial begin
        int wins;
        m_gain = 24'd65536; m_offset = 0; m_hascal = 0; m_winms = 16'd1000;
        m_satfrac = 16'd655;
        clear_window();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default scaling and flags after reset, short window
        cfg_write(CFG_WINMS, 24'd3);
        push_sample(12'd0); push_sample(ADC_FULL); push_sample(12'd2048);
        push_ticks(3);
        drain();

        // Extreme gain/offset, rail samples, calibration present
        cfg_write(CFG_WINMS, 24'd1);
        cfg_write(CFG_HASCAL, 24'd1);
        cfg_write(CFG_GAIN, 24'h7FFFFF);
        cfg_write(CFG_OFFSET, 24'h7FFFFF);
        cfg_write(3'd5, 24'hFFFFFF);
        cfg_write(3'd7, 24'h123456);
        push_sample(ADC_FULL); push_sample(12'd0); push_ticks(1);
        push_ticks(1);
        push_sample(12'd1); push_sample(12'hAAA); push_sample(12'h555); push_ticks(1);
        drain();
        cfg_write(CFG_GAIN, 24'h800000);
        cfg_write(CFG_OFFSET, 24'h800000);
        cfg_write(CFG_SATFRAC, 24'd0);
        push_sample(12'd4094); push_sample(12'd7); push_ticks(1);
        push_sample(12'd0); push_ticks(1);
        drain();
        cfg_write(CFG_SATFRAC, 24'hFFFF);
        cfg_write(CFG_OFFSET, 24'd0);
        cfg_write(CFG_GAIN, 24'hFFFFFF);
        repeat (4) push_sample(ADC_FULL);
        push_sample(12'd100); push_ticks(1);
        drain();

        // Window length zero: every tick closes
        cfg_write(CFG_WINMS, 24'd0);
        push_sample(12'd300); push_ticks(2); push_sample(12'd5); push_ticks(1);
        drain();

        // Random phases, varied settings; one with a long receiver hold-off
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_GAIN, 24'($urandom_range(3) == 0 ? $urandom : $urandom_range(200000)));
            cfg_write(CFG_OFFSET, 24'($urandom));
            cfg_write(CFG_HASCAL, 24'($urandom_range(1)));
            cfg_write(CFG_WINMS, 24'($urandom_range(4, 1)));
            cfg_write(CFG_SATFRAC, 24'($urandom_range(3) == 0 ? $urandom : $urandom_range(20000)));
            tx_quiet = (ph == 2);
            rx_quiet = (ph == 5);
            if (ph == 3) begin
                rx_hold = 600;
                for (wins = 0; wins < 20; wins++) begin
                    push_sample(rand_raw());
                    push_ticks(m_winms);
                end
            end
            for (wins = 0; wins < 18; wins++) push_window(10);
            drain();
        end
        tx_quiet = 0;
        rx_quiet = 0;

        $display("checked %0d window reports from %0d input items", reports_seen, items_sent);
        $display("covered gain/offset extremes, rails, empty windows, zero length, stalls");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
